// ===== rtl/core/fdjq_pkg.sv =====
// fdjq_pkg: shared types and constants of the deadline job queue
// no dependencies; imported by fdjq_serve_unit and fifo_deadline_job_queue
package fdjq_pkg;

	localparam int ID_W   = 16;
	localparam int TIME_W = 24;
	localparam int EVT_W  = 25;
	localparam int CAP_W  = 3;

	// opcodes of an input item
	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// outcome codes of a result
	localparam logic OUTCOME_DONE  = 1'b0;
	localparam logic OUTCOME_ABORT = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 3'd3;

	typedef struct packed {
		logic              opcode;
		logic [ID_W-1:0]   job_id;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] run_length;
		logic [TIME_W-1:0] deadline;
	} in_item_t;

	typedef struct packed {
		logic             outcome;
		logic [ID_W-1:0]  done_job_id;
		logic [EVT_W-1:0] event_time;
		logic [EVT_W-1:0] wait_delay;
		logic             last;
	} out_item_t;

	// one waiting job as held in the queue memory
	typedef struct packed {
		logic [ID_W-1:0]   job_id;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] run_length;
		logic [TIME_W-1:0] deadline;
	} slot_t;

endpackage

// ===== rtl/core/fifo_deadline_job_queue.sv =====
// fifo_deadline_job_queue: single-server fifo job queue with deadlines
// depends on fdjq_pkg and fdjq_serve_unit
//
// usage
//  - item channel (item_valid/item_ready/item): offer a job or drain the queue
//  - result channel (result_valid/result_ready/result): one transfer per
//    completed, aborted or rejected job; last marks the final result of an item
//  - cfg channel (cfg_valid/cfg_ready/cfg_data): writes queue_capacity, taken
//    at any time but meant only while the block is idle
//  - one item at a time: item_ready is high only while the sequencer is idle
//  - each served job passes in turn through decide and read, the shared serve
//    unit and hand off; a result stall can hold the hand-off, and item_ready
//    stays low until the whole item is finished and the sequencer is idle
//  - results are held one back in a pending register so that the last flag
//    is known before the result reaches the output register
//  - an offered job that is queued gives no result of its own
//  - a stall on result_ready holds the sequencer at its next hand-off; the
//    output register keeps its transfer stable meanwhile
//  - reset empties the queue, zeroes the server free time and sets the
//    capacity to 3; queue memory contents are not cleared
module fifo_deadline_job_queue #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  fdjq_pkg::in_item_t          item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output fdjq_pkg::out_item_t         result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fdjq_pkg::CAP_W-1:0]  cfg_data
);
	import fdjq_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_CALC  = 3'd2;
	localparam logic [2:0] ST_PUT   = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]       state_q;
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] waiting_q;
	logic [IDX_W-1:0] head_q;
	logic [EVT_W-1:0] free_q;
	logic             final_q;
	logic             pend_valid_q;
	logic             out_valid_q;

	in_item_t         item_q;
	out_item_t        new_q;
	out_item_t        pend_q;
	out_item_t        out_q;
	slot_t            rd_q;
	slot_t            mem [QUEUE_DEPTH];

	logic             arr_ge_f;
	logic             has_room;
	logic             do_serve;
	logic             do_start;
	logic             do_enq;
	logic             do_reject;
	logic             out_free;
	logic             put_go;
	logic             flush_go;
	logic [EVT_W-1:0] start_sum;
	logic [IDX_W:0]   tail_sum;
	logic [IDX_W-1:0] tail;
	logic [IDX_W-1:0] head_next;
	slot_t            slot_wr;
	out_item_t        serve_res;
	logic [EVT_W-1:0] serve_free;
	out_item_t        out_next;

	fdjq_serve_unit u_serve (
		.slot      (rd_q),
		.free_time (free_q),
		.res       (serve_res),
		.free_next (serve_free)
	);

	assign item_ready   = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		arr_ge_f  = EVT_W'(item_q.arrival_time) >= free_q;
		// effective capacity is the smaller of register and depth
		has_room  = (CMP_W'(waiting_q) < CMP_W'(cap_q)) &&
			(waiting_q < CNT_W'(QUEUE_DEPTH));
		do_serve  = (state_q == ST_EVAL) && (waiting_q != '0) &&
			((item_q.opcode == OP_DRAIN) || arr_ge_f);
		do_start  = (state_q == ST_EVAL) && !do_serve &&
			(item_q.opcode == OP_OFFER) && arr_ge_f;
		do_enq    = (state_q == ST_EVAL) && (item_q.opcode == OP_OFFER) &&
			!arr_ge_f && has_room;
		do_reject = (state_q == ST_EVAL) && (item_q.opcode == OP_OFFER) &&
			!arr_ge_f && !has_room;
		out_free  = !out_valid_q || result_ready;
		put_go    = (state_q == ST_PUT) && (!pend_valid_q || out_free);
		flush_go  = (state_q == ST_FLUSH) && (!pend_valid_q || out_free);
		start_sum = EVT_W'(item_q.arrival_time) + EVT_W'(item_q.run_length);

		// tail = (head + waiting) mod depth, sum stays below twice the depth
		tail_sum = (IDX_W+1)'(head_q) + (IDX_W+1)'(waiting_q);
		if (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH))
			tail = IDX_W'(tail_sum - (IDX_W+1)'(QUEUE_DEPTH));
		else
			tail = IDX_W'(tail_sum);

		if (head_q == IDX_W'(QUEUE_DEPTH - 1))
			head_next = '0;
		else
			head_next = head_q + IDX_W'(1);

		slot_wr.job_id       = item_q.job_id;
		slot_wr.arrival_time = item_q.arrival_time;
		slot_wr.run_length   = item_q.run_length;
		slot_wr.deadline     = item_q.deadline;

		// only the flush hand-off carries the final result of an item
		out_next      = pend_q;
		out_next.last = flush_go;
	end

	// queue memory, registered read of the head slot
	always_ff @(posedge clk) begin
		if (do_enq)
			mem[tail] <= slot_wr;
		if (do_serve)
			rd_q <= mem[head_q];
	end

	// sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CAP_RESET;
			waiting_q    <= '0;
			head_q       <= '0;
			free_q       <= '0;
			final_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_q <= cfg_data;

			case (state_q)
				ST_IDLE: begin
					if (item_valid)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (do_serve) begin
						state_q <= ST_CALC;
					end else if (do_start) begin
						free_q  <= start_sum;
						final_q <= 1'b1;
						state_q <= ST_PUT;
					end else if (do_reject) begin
						final_q <= 1'b1;
						state_q <= ST_PUT;
					end else if (do_enq) begin
						waiting_q <= waiting_q + CNT_W'(1);
						state_q   <= ST_FLUSH;
					end else begin
						// drain found the queue empty
						state_q <= ST_FLUSH;
					end
				end
				ST_CALC: begin
					free_q    <= serve_free;
					head_q    <= head_next;
					waiting_q <= waiting_q - CNT_W'(1);
					final_q   <= 1'b0;
					state_q   <= ST_PUT;
				end
				ST_PUT: begin
					if (put_go) begin
						pend_valid_q <= 1'b1;
						state_q      <= final_q ? ST_FLUSH : ST_EVAL;
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// output register: load from pending, else clear on transfer
			if ((put_go || flush_go) && pend_valid_q)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_q <= item;

		if (do_start) begin
			new_q.outcome     <= OUTCOME_DONE;
			new_q.done_job_id <= item_q.job_id;
			new_q.event_time  <= start_sum;
			new_q.wait_delay  <= '0;
			new_q.last        <= 1'b0;
		end else if (do_reject) begin
			new_q.outcome     <= OUTCOME_ABORT;
			new_q.done_job_id <= item_q.job_id;
			new_q.event_time  <= EVT_W'(item_q.arrival_time);
			new_q.wait_delay  <= '0;
			new_q.last        <= 1'b0;
		end else if (state_q == ST_CALC) begin
			new_q <= serve_res;
		end

		if (put_go)
			pend_q <= new_q;

		if ((put_go || flush_go) && pend_valid_q)
			out_q <= out_next;
	end

endmodule

// ===== rtl/core/fdjq_serve_unit.sv =====
// fdjq_serve_unit: serves one waiting job against the server free time
// depends on fdjq_pkg
module fdjq_serve_unit (
	input  fdjq_pkg::slot_t         slot,
	input  logic [24:0]             free_time,
	output fdjq_pkg::out_item_t     res,
	output logic [24:0]             free_next
);
	import fdjq_pkg::*;

	logic [EVT_W:0]   finish;
	logic             overrun;
	logic             free_before_dl;
	logic [EVT_W-1:0] dl_ext;
	logic [EVT_W-1:0] arr_ext;

	always_comb begin
		dl_ext         = EVT_W'(slot.deadline);
		arr_ext        = EVT_W'(slot.arrival_time);
		finish         = (EVT_W+1)'(free_time) + (EVT_W+1)'(slot.run_length);
		overrun        = finish > (EVT_W+1)'(slot.deadline);
		free_before_dl = free_time < dl_ext;

		res.done_job_id = slot.job_id;
		res.last        = 1'b0;
		if (overrun && free_before_dl) begin
			// cut off at the deadline
			res.outcome    = OUTCOME_ABORT;
			res.event_time = dl_ext;
			res.wait_delay = dl_ext - arr_ext;
			free_next      = dl_ext;
		end else if (overrun) begin
			// deadline already gone when the server frees up
			res.outcome    = OUTCOME_ABORT;
			res.event_time = free_time;
			res.wait_delay = free_time - arr_ext;
			free_next      = free_time;
		end else begin
			res.outcome    = OUTCOME_DONE;
			res.event_time = finish[EVT_W-1:0];
			res.wait_delay = free_time - arr_ext;
			free_next      = finish[EVT_W-1:0];
		end
	end

endmodule
